/* design/x86d_pkg.sv */
// Package: types, codes and the opcode classifier for the x86 decoder.
package x86d_pkg;

    localparam int MaxBytes = 6;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_UNKNOWN  = 3'd1,
        ST_NO_MODRM = 3'd2,
        ST_NO_WORD  = 3'd3,
        ST_NO_BYTE  = 3'd4,
        ST_BAD_SUB  = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        K_UNK, K_BAD, K_ACC_IMM, K_RM_REG, K_MOV_RM_IMM, K_MOV_ACC,
        K_GROUP, K_JUMP, K_MOV_REG_IMM
    } t_kind;

    localparam logic [4:0] OpAdd = 5'd0;
    localparam logic [4:0] OpSub = 5'd1;
    localparam logic [4:0] OpCmp = 5'd2;
    localparam logic [4:0] OpMov = 5'd3;
    localparam logic [4:0] OpJmpBase = 5'd4;
    localparam logic [4:0] OpLoopBase = 5'd20;
    localparam logic [4:0] OpBad = 5'd31;

    localparam logic [3:0] FmRegReg = 4'd0;
    localparam logic [3:0] FmRegImm = 4'd2;
    localparam logic [3:0] FmDirect = 4'd3;
    localparam logic [3:0] FmRegDirect = 4'd4;
    localparam logic [3:0] FmIndirect = 4'd5;
    localparam logic [3:0] FmDisp8 = 4'd7;
    localparam logic [3:0] FmDisp16 = 4'd9;
    localparam logic [3:0] FmDirImm = 4'd11;
    localparam logic [3:0] FmIndImm = 4'd12;
    localparam logic [3:0] FmD8Imm = 4'd13;
    localparam logic [3:0] FmD16Imm = 4'd14;
    localparam logic [3:0] FmIpRel = 4'd15;

    typedef struct packed {
        t_kind      kind;
        logic [4:0] oper;
        logic       wide;
        logic       dir;
        logic       sign;
        logic       modrm;
        logic [1:0] fixdisp;
        logic [1:0] imm;
    } t_opinfo;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  operation;
        logic [3:0]  operand_form;
        logic        word_size;
        logic        sign_extend;
        logic [3:0]  register_index;
        logic [3:0]  regmem_index;
        logic [16:0] displacement;
        logic [16:0] immediate;
        logic [2:0]  byte_length;
    } t_record;

    function automatic logic [4:0] arith_code(input logic [2:0] code);
        case (code)
            3'd0:    arith_code = OpAdd;
            3'd5:    arith_code = OpSub;
            3'd7:    arith_code = OpCmp;
            default: arith_code = OpBad;
        endcase
    endfunction

    function automatic t_opinfo classify(input logic [7:0] op);
        t_opinfo k;
        k = '0;
        k.kind = K_UNK;
        k.wide = op[0];
        if ((op & 8'hC6) == 8'h04) begin
            k.oper = arith_code(op[5:3]);
            k.kind = (k.oper == OpBad) ? K_BAD : K_ACC_IMM;
            k.imm = op[0] ? 2'd2 : 2'd1;
        end else if ((op & 8'hC4) == 8'h00) begin
            k.oper = arith_code(op[5:3]);
            k.kind = (k.oper == OpBad) ? K_BAD : K_RM_REG;
            k.dir = op[1];
            k.modrm = 1'b1;
        end else if ((op & 8'hFE) == 8'hC6) begin
            k.kind = K_MOV_RM_IMM; k.oper = OpMov; k.modrm = 1'b1;
            k.imm = op[0] ? 2'd2 : 2'd1;
        end else if ((op & 8'hFC) == 8'hA0) begin
            k.kind = K_MOV_ACC; k.oper = OpMov; k.fixdisp = 2'd2; k.dir = op[1];
        end else if ((op & 8'hFC) == 8'h80) begin
            k.kind = K_GROUP; k.modrm = 1'b1; k.sign = op[1];
            k.imm = (op[0] && !op[1]) ? 2'd2 : 2'd1;
        end else if ((op & 8'hFC) == 8'h88) begin
            k.kind = K_RM_REG; k.oper = OpMov; k.modrm = 1'b1; k.dir = op[1];
        end else if ((op & 8'hFC) == 8'hE0) begin
            k.kind = K_JUMP; k.oper = OpLoopBase + {3'd0, op[1:0]};
            k.imm = 2'd1; k.wide = 1'b0;
        end else if ((op & 8'hF0) == 8'hB0) begin
            k.kind = K_MOV_REG_IMM; k.oper = OpMov; k.wide = op[3];
            k.imm = op[3] ? 2'd2 : 2'd1;
        end else if ((op & 8'hF0) == 8'h70) begin
            k.kind = K_JUMP; k.oper = OpJmpBase + {1'b0, op[3:0]};
            k.imm = 2'd1; k.wide = 1'b0;
        end
        return k;
    endfunction

    function automatic logic [16:0] sext8(input logic [7:0] v);
        return {{9{v[7]}}, v};
    endfunction

endpackage

/* design/x86d_if.sv */
// Interfaces: byte input channel and decoded record channel.
interface x86d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       stream_end;
    modport source (output valid, code_byte, stream_end, input ready);
    modport sink (input valid, code_byte, stream_end, output ready);
endinterface

interface x86d_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [4:0]  operation;
    logic [3:0]  operand_form;
    logic        word_size;
    logic        sign_extend;
    logic [3:0]  register_index;
    logic [3:0]  regmem_index;
    logic [16:0] displacement;
    logic [16:0] immediate;
    logic [2:0]  byte_length;
    modport source (output valid, status, operation, operand_form, word_size, sign_extend,
        register_index, regmem_index, displacement, immediate, byte_length, input ready);
    modport sink (input valid, status, operation, operand_form, word_size, sign_extend,
        register_index, regmem_index, displacement, immediate, byte_length, output ready);
endinterface

/* design/x86d_front.sv */
// Front end: collects bytes, classifies the opcode and builds one record per instruction.
module x86d_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_code_byte,
    input  logic             i_stream_end,
    output logic             o_rec_valid,
    output x86d_pkg::t_record o_rec,
    input  logic             i_q_full
);
    logic [7:0] r_held [x86d_pkg::MaxBytes];
    logic [2:0] r_taken;
    logic [2:0] r_needed;
    logic [2:0] n_taken;

    logic [7:0] b [x86d_pkg::MaxBytes];
    logic [2:0] pos, t, total, dstart, dlen;
    x86d_pkg::t_opinfo k;
    x86d_pkg::t_record rec;
    logic emit;
    logic [4:0] oper;
    logic [1:0] disp;
    logic [1:0] mode;
    logic [2:0] rm;
    logic [16:0] dval, ival;
    logic [15:0] ival_raw;
    logic [3:0] form;
    logic [2:0] ipos;

    assign o_ready = !i_q_full;
    assign pos = (r_taken >= 3'(x86d_pkg::MaxBytes)) ? 3'd0 : r_taken;
    assign t = pos + 3'd1;

    always_comb begin
        for (int j = 0; j < x86d_pkg::MaxBytes; j++) begin
            b[j] = (3'(j) == pos) ? i_code_byte : r_held[j];
        end
    end

    always_comb begin
        k = x86d_pkg::classify(b[0]);
        oper = k.oper;
        rec = '0;
        emit = 1'b0;
        disp = k.fixdisp;
        mode = b[1][7:6];
        rm = b[1][2:0];
        total = 3'd0;
        dval = '0;
        ival = '0;
        ival_raw = '0;
        form = '0;
        dstart = 3'd1 + {2'd0, k.modrm};
        dlen = '0;
        ipos = '0;
        rec.byte_length = t;
        if (k.kind == x86d_pkg::K_UNK) begin
            emit = 1'b1; rec.status = x86d_pkg::ST_UNKNOWN;
        end else if (k.kind == x86d_pkg::K_BAD) begin
            emit = 1'b1; rec.status = x86d_pkg::ST_BAD_SUB;
        end else begin
            if (k.modrm && t >= 3'd2) begin
                if (k.kind == x86d_pkg::K_GROUP) oper = x86d_pkg::arith_code(b[1][5:3]);
                if (mode == 2'd1) disp = 2'd1;
                else if (mode == 2'd2) disp = 2'd2;
                else if (mode == 2'd0 && rm == 3'd6) disp = 2'd2;
                total = 3'd2 + {1'b0, disp} + {1'b0, k.imm};
            end else if (!k.modrm) begin
                total = 3'd1 + {1'b0, disp} + {1'b0, k.imm};
            end
            dlen = dstart + {1'b0, disp};
            ipos = dlen;
            if (oper == x86d_pkg::OpBad) begin
                emit = 1'b1; rec.status = x86d_pkg::ST_BAD_SUB;
            end else if (total == 3'd0 || t < total) begin
                emit = i_stream_end;
                if (total == 3'd0) rec.status = x86d_pkg::ST_NO_MODRM;
                else if (t < dlen)
                    rec.status = (disp == 2'd2) ? x86d_pkg::ST_NO_WORD : x86d_pkg::ST_NO_BYTE;
                else
                    rec.status = (k.imm == 2'd2) ? x86d_pkg::ST_NO_WORD : x86d_pkg::ST_NO_BYTE;
            end else begin
                emit = 1'b1;
                if (disp == 2'd1) dval = x86d_pkg::sext8(b[dstart]);
                else if (disp == 2'd2) dval = {1'b0, b[dstart + 3'd1], b[dstart]};
                if (k.imm == 2'd1) ival_raw = {8'd0, b[ipos]};
                else if (k.imm == 2'd2) ival_raw = {b[ipos + 3'd1], b[ipos]};
                ival = {1'b0, ival_raw};
                rec.register_index = '0;
                if (k.modrm) begin
                    rec.regmem_index = {(mode == 2'd3) & k.wide, rm};
                    rec.register_index = {k.wide, b[1][5:3]};
                    if (mode == 2'd3) form = x86d_pkg::FmRegReg;
                    else if (mode == 2'd0)
                        form = (rm == 3'd6) ? x86d_pkg::FmDirect : x86d_pkg::FmIndirect;
                    else if (dval == '0) form = x86d_pkg::FmIndirect;
                    else form = (mode == 2'd1) ? x86d_pkg::FmDisp8 : x86d_pkg::FmDisp16;
                    if (k.kind == x86d_pkg::K_GROUP) rec.register_index = rec.regmem_index;
                    if (k.kind == x86d_pkg::K_GROUP || k.kind == x86d_pkg::K_MOV_RM_IMM) begin
                        case (form)
                            x86d_pkg::FmRegReg:   form = x86d_pkg::FmRegImm;
                            x86d_pkg::FmDirect:   form = x86d_pkg::FmDirImm;
                            x86d_pkg::FmIndirect: form = x86d_pkg::FmIndImm;
                            x86d_pkg::FmDisp8:    form = x86d_pkg::FmD8Imm;
                            default:              form = x86d_pkg::FmD16Imm;
                        endcase
                    end else if (k.dir) begin
                        form = form + 4'd1;
                    end
                end else if (k.kind == x86d_pkg::K_ACC_IMM) begin
                    form = x86d_pkg::FmRegImm; rec.register_index = {k.wide, 3'd0};
                end else if (k.kind == x86d_pkg::K_MOV_ACC) begin
                    form = k.dir ? x86d_pkg::FmDirect : x86d_pkg::FmRegDirect;
                    rec.register_index = {k.wide, 3'd0};
                end else if (k.kind == x86d_pkg::K_MOV_REG_IMM) begin
                    form = x86d_pkg::FmRegImm; rec.register_index = {k.wide, b[0][2:0]};
                end else begin
                    form = x86d_pkg::FmIpRel;
                    ival = x86d_pkg::sext8(ival_raw[7:0]);
                end
                rec.status = x86d_pkg::ST_OK;
                rec.operation = oper;
                rec.operand_form = form;
                rec.word_size = k.wide;
                rec.sign_extend = k.sign;
                rec.displacement = dval;
                rec.immediate = ival;
            end
        end
        n_taken = emit ? 3'd0 : t;
    end

    assign o_rec_valid = i_valid && o_ready && emit;
    assign o_rec = rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= '0;
            r_needed <= '0;
        end else if (i_valid && o_ready) begin
            r_taken <= n_taken;
            r_needed <= emit ? 3'd0 : total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) r_held[pos] <= i_code_byte;
    end

    property p_taken_range;
        @(posedge i_clk) disable iff (!i_rst_n) r_taken <= 3'(x86d_pkg::MaxBytes);
    endproperty
    a_taken_range: assert property (p_taken_range) else $error("byte count out of range");

    property p_emit_clears;
        @(posedge i_clk) disable iff (!i_rst_n) o_rec_valid |=> r_taken == 3'd0;
    endproperty
    a_emit_clears: assert property (p_emit_clears) else $error("count not cleared");

    property p_needed_known;
        @(posedge i_clk) disable iff (!i_rst_n) (r_taken == 3'd0) |-> r_needed == 3'd0;
    endproperty
    a_needed_known: assert property (p_needed_known) else $error("stale length");
endmodule

/* design/x86d_queue.sv */
// Back end: short record queue that decouples the decoder from the result receiver.
module x86d_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  x86d_pkg::t_record i_rec,
    output logic              o_full,
    output logic              o_valid,
    output x86d_pkg::t_record o_rec,
    input  logic              i_pop
);
    x86d_pkg::t_record r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic do_pop;

    assign o_full = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_rec = r_mem[r_rp];
    assign do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (do_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_rec;
    end

    property p_no_overflow;
        @(posedge i_clk) disable iff (!i_rst_n) o_full |-> !i_push;
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

    property p_count_ptrs;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_wp == r_rp;
    endproperty
    a_count_ptrs: assert property (p_count_ptrs) else $error("pointer mismatch");

    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n) (o_valid && !i_pop) |=> $stable(o_rec);
    endproperty
    a_hold: assert property (p_hold) else $error("head changed under stall");
endmodule

/* design/x86_16bit_instruction_decoder.sv */
// Top level: 8086 instruction decoder, byte stream in, one record per instruction out.
// Usage:
//   i_in carries one code byte per item, with stream_end on the final byte available.
//   o_out carries one decoded record per complete instruction, or an error record
//   (unknown opcode, bad sub-opcode, truncation) after which decoding restarts.
//   A byte that does not complete an instruction produces no record.
// The queue registers each record; o_out presents it once earlier records are taken.
// Throughput: one byte per cycle while the queue is not full; the front end decodes
//   each byte combinationally against the bytes held so far, pushing to a two-entry record queue.
// Stall: when the receiver holds ready low the queue fills; the input is refused
//   only while the queue is full, so up to two records wait without loss.
// Reset: synchronous active-low; clears the byte count and empties the queue.
module x86_16bit_instruction_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    x86d_in_if.sink     i_in,
    x86d_out_if.source  o_out
);
    logic              rec_valid, q_full, q_valid;
    x86d_pkg::t_record rec, q_rec;

    x86d_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(i_in.valid), .o_ready(i_in.ready),
        .i_code_byte(i_in.code_byte), .i_stream_end(i_in.stream_end),
        .o_rec_valid(rec_valid), .o_rec(rec), .i_q_full(q_full)
    );

    x86d_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push(rec_valid), .i_rec(rec), .o_full(q_full),
        .o_valid(q_valid), .o_rec(q_rec), .i_pop(o_out.ready)
    );

    assign o_out.valid = q_valid;
    assign o_out.status = q_rec.status;
    assign o_out.operation = q_rec.operation;
    assign o_out.operand_form = q_rec.operand_form;
    assign o_out.word_size = q_rec.word_size;
    assign o_out.sign_extend = q_rec.sign_extend;
    assign o_out.register_index = q_rec.register_index;
    assign o_out.regmem_index = q_rec.regmem_index;
    assign o_out.displacement = q_rec.displacement;
    assign o_out.immediate = q_rec.immediate;
    assign o_out.byte_length = q_rec.byte_length;
endmodule

/* sim/x86_16bit_instruction_decoder_tb.sv */
// Testbench: byte-stream stimulus against an 8086 decode predictor, records checked in order.
`timescale 1ns / 100ps

module x86_16bit_instruction_decoder_tb;

    localparam int CycleLimit = 200000;

    class decode_scoreboard;
        logic [7:0] held [x86d_pkg::MaxBytes];
        int unsigned taken;
        x86d_pkg::t_record expected_q[$];
        int unsigned mismatches;
        int unsigned records_seen;
        int unsigned error_records;

        function new();
            taken = 0;
            mismatches = 0;
            records_seen = 0;
            error_records = 0;
        endfunction

        function logic [4:0] sub_op(input logic [2:0] code);
            case (code)
                3'd0:    return x86d_pkg::OpAdd;
                3'd5:    return x86d_pkg::OpSub;
                3'd7:    return x86d_pkg::OpCmp;
                default: return x86d_pkg::OpBad;
            endcase
        endfunction

        function logic [16:0] widen8(input logic [7:0] v);
            return {{9{v[7]}}, v};
        endfunction

        function void push_error(input x86d_pkg::t_status st, input int unsigned len);
            x86d_pkg::t_record r;
            r = '0;
            r.status = st;
            r.byte_length = len[2:0];
            expected_q.push_back(r);
            error_records++;
            taken = 0;
        endfunction

        function bit busy();
            return taken != 0;
        endfunction

        // Called once per accepted byte.
        function void note(input logic [7:0] b, input logic last);
            x86d_pkg::t_kind kind;
            x86d_pkg::t_record r;
            logic [7:0] op, m;
            logic [4:0] oper;
            logic wide, dir, sgn, has_modrm;
            logic [16:0] dval, ival;
            logic [3:0] form, reg_i, rm_i;
            int unsigned t, dlen, ilen, total, dstart;
            logic [1:0] md;
            logic [2:0] rm;
            if (taken >= x86d_pkg::MaxBytes) taken = 0;
            held[taken] = b;
            taken++;
            t = taken;
            op = held[0];
            kind = x86d_pkg::K_UNK;
            oper = '0; wide = op[0]; dir = 1'b0; sgn = 1'b0; has_modrm = 1'b0;
            dlen = 0; ilen = 0;
            if ((op & 8'hC6) == 8'h04) begin
                oper = sub_op(op[5:3]);
                kind = (oper == x86d_pkg::OpBad) ? x86d_pkg::K_BAD : x86d_pkg::K_ACC_IMM;
                ilen = op[0] ? 2 : 1;
            end else if ((op & 8'hC4) == 8'h00) begin
                oper = sub_op(op[5:3]);
                kind = (oper == x86d_pkg::OpBad) ? x86d_pkg::K_BAD : x86d_pkg::K_RM_REG;
                dir = op[1]; has_modrm = 1'b1;
            end else if (op[7:1] == 7'b1100011) begin
                kind = x86d_pkg::K_MOV_RM_IMM; oper = x86d_pkg::OpMov; has_modrm = 1'b1;
                ilen = op[0] ? 2 : 1;
            end else if (op[7:2] == 6'b101000) begin
                kind = x86d_pkg::K_MOV_ACC; oper = x86d_pkg::OpMov; dlen = 2; dir = op[1];
            end else if (op[7:2] == 6'b100000) begin
                kind = x86d_pkg::K_GROUP; has_modrm = 1'b1; sgn = op[1];
                ilen = (op[0] && !op[1]) ? 2 : 1;
            end else if (op[7:2] == 6'b100010) begin
                kind = x86d_pkg::K_RM_REG; oper = x86d_pkg::OpMov; has_modrm = 1'b1;
                dir = op[1];
            end else if (op[7:2] == 6'b111000) begin
                kind = x86d_pkg::K_JUMP; oper = x86d_pkg::OpLoopBase + {3'd0, op[1:0]};
                ilen = 1; wide = 1'b0;
            end else if (op[7:4] == 4'hB) begin
                kind = x86d_pkg::K_MOV_REG_IMM; oper = x86d_pkg::OpMov; wide = op[3];
                ilen = op[3] ? 2 : 1;
            end else if (op[7:4] == 4'h7) begin
                kind = x86d_pkg::K_JUMP; oper = x86d_pkg::OpJmpBase + {1'b0, op[3:0]};
                ilen = 1; wide = 1'b0;
            end
            if (kind == x86d_pkg::K_UNK) begin
                push_error(x86d_pkg::ST_UNKNOWN, t);
                return;
            end
            if (kind == x86d_pkg::K_BAD) begin
                push_error(x86d_pkg::ST_BAD_SUB, t);
                return;
            end
            m = '0; md = '0; rm = '0; total = 0;
            if (has_modrm) begin
                if (t >= 2) begin
                    m = held[1];
                    md = m[7:6];
                    rm = m[2:0];
                    if (kind == x86d_pkg::K_GROUP) begin
                        oper = sub_op(m[5:3]);
                        if (oper == x86d_pkg::OpBad) begin
                            push_error(x86d_pkg::ST_BAD_SUB, t);
                            return;
                        end
                    end
                    if (md == 2'd1) dlen = 1;
                    else if (md == 2'd2) dlen = 2;
                    else if (md == 2'd0 && rm == 3'd6) dlen = 2;
                    total = 2 + dlen + ilen;
                end
            end else begin
                total = 1 + dlen + ilen;
            end
            dstart = 1 + has_modrm;
            if (total == 0 || t < total) begin
                if (!last) return;
                if (total == 0) push_error(x86d_pkg::ST_NO_MODRM, t);
                else if (t < dstart + dlen)
                    push_error(dlen == 2 ? x86d_pkg::ST_NO_WORD : x86d_pkg::ST_NO_BYTE, t);
                else
                    push_error(ilen == 2 ? x86d_pkg::ST_NO_WORD : x86d_pkg::ST_NO_BYTE, t);
                return;
            end
            dval = '0; ival = '0; form = '0; reg_i = '0; rm_i = '0;
            if (dlen == 1) dval = widen8(held[dstart]);
            else if (dlen == 2) dval = {1'b0, held[dstart + 1], held[dstart]};
            if (ilen == 1) ival = {9'd0, held[dstart + dlen]};
            else if (ilen == 2) ival = {1'b0, held[dstart + dlen + 1], held[dstart + dlen]};
            if (has_modrm) begin
                rm_i = {1'b0, rm} + ((md == 2'd3 && wide) ? 4'd8 : 4'd0);
                reg_i = {1'b0, m[5:3]} + (wide ? 4'd8 : 4'd0);
                if (md == 2'd3) form = x86d_pkg::FmRegReg;
                else if (md == 2'd0)
                    form = (rm == 3'd6) ? x86d_pkg::FmDirect : x86d_pkg::FmIndirect;
                else if (dval == 17'd0) form = x86d_pkg::FmIndirect;
                else form = (md == 2'd1) ? x86d_pkg::FmDisp8 : x86d_pkg::FmDisp16;
                if (kind == x86d_pkg::K_GROUP) reg_i = rm_i;
                if (kind == x86d_pkg::K_GROUP || kind == x86d_pkg::K_MOV_RM_IMM) begin
                    case (form)
                        x86d_pkg::FmRegReg:   form = x86d_pkg::FmRegImm;
                        x86d_pkg::FmDirect:   form = x86d_pkg::FmDirImm;
                        x86d_pkg::FmIndirect: form = x86d_pkg::FmIndImm;
                        x86d_pkg::FmDisp8:    form = x86d_pkg::FmD8Imm;
                        default:              form = x86d_pkg::FmD16Imm;
                    endcase
                end else if (dir) begin
                    form = form + 4'd1;
                end
            end else if (kind == x86d_pkg::K_ACC_IMM) begin
                form = x86d_pkg::FmRegImm; reg_i = wide ? 4'd8 : 4'd0;
            end else if (kind == x86d_pkg::K_MOV_ACC) begin
                form = dir ? x86d_pkg::FmDirect : x86d_pkg::FmRegDirect;
                reg_i = wide ? 4'd8 : 4'd0;
            end else if (kind == x86d_pkg::K_MOV_REG_IMM) begin
                form = x86d_pkg::FmRegImm; reg_i = {1'b0, op[2:0]} + (wide ? 4'd8 : 4'd0);
            end else begin
                form = x86d_pkg::FmIpRel;
                ival = widen8(ival[7:0]);
            end
            r.status = x86d_pkg::ST_OK;
            r.operation = oper;
            r.operand_form = form;
            r.word_size = wide;
            r.sign_extend = sgn;
            r.register_index = reg_i;
            r.regmem_index = rm_i;
            r.displacement = dval;
            r.immediate = ival;
            r.byte_length = t[2:0];
            expected_q.push_back(r);
            taken = 0;
        endfunction

        function void cmp(input string name, input logic [16:0] e, input logic [16:0] a);
            if (e !== a) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
                mismatches++;
            end
        endfunction

        function void check(input x86d_pkg::t_record a);
            x86d_pkg::t_record e;
            records_seen++;
            if (expected_q.size() == 0) begin
                $error("record with none expected: status %0d op %0d", a.status, a.operation);
                mismatches++;
                return;
            end
            e = expected_q.pop_front();
            cmp("status", 17'(e.status), 17'(a.status));
            cmp("operation", 17'(e.operation), 17'(a.operation));
            cmp("operand_form", 17'(e.operand_form), 17'(a.operand_form));
            cmp("word_size", 17'(e.word_size), 17'(a.word_size));
            cmp("sign_extend", 17'(e.sign_extend), 17'(a.sign_extend));
            cmp("register_index", 17'(e.register_index), 17'(a.register_index));
            cmp("regmem_index", 17'(e.regmem_index), 17'(a.regmem_index));
            cmp("displacement", e.displacement, a.displacement);
            cmp("immediate", e.immediate, a.immediate);
            cmp("byte_length", 17'(e.byte_length), 17'(a.byte_length));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    x86d_in_if in_ch();
    x86d_out_if out_ch();
    decode_scoreboard sb;
    bit quiet;
    bit hold_req;
    int unsigned cycles;
    int unsigned n_bytes;

    x86_16bit_instruction_decoder DUT (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("x86_16bit_instruction_decoder_tb: FAIL");
            $finish;
        end
    end

    // Record sink with random stalls and one long hold-off.
    initial begin : sink_proc
        int unsigned stall_left;
        x86d_pkg::t_record a;
        stall_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready) begin
                a.status = out_ch.status;
                a.operation = out_ch.operation;
                a.operand_form = out_ch.operand_form;
                a.word_size = out_ch.word_size;
                a.sign_extend = out_ch.sign_extend;
                a.register_index = out_ch.register_index;
                a.regmem_index = out_ch.regmem_index;
                a.displacement = out_ch.displacement;
                a.immediate = out_ch.immediate;
                a.byte_length = out_ch.byte_length;
                sb.check(a);
            end
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = 400;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (quiet || $urandom_range(0, 5) != 0) begin
                out_ch.ready <= 1'b1;
            end else begin
                stall_left = $urandom_range(0, 5);
                out_ch.ready <= 1'b0;
            end
        end
    end

    task automatic send(input logic [7:0] b, input logic last);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.code_byte <= b;
        in_ch.stream_end <= last;
        do @(posedge clk); while (!in_ch.ready);
        sb.note(b, last);
        n_bytes++;
    endtask

    function automatic logic [7:0] pick_opcode();
        logic [2:0] s;
        s = ($urandom_range(0, 2) == 0) ? 3'd0 : (($urandom_range(0, 1) != 0) ? 3'd5 : 3'd7);
        case ($urandom_range(0, 9))
            0: return {2'b00, s, 1'b0, $urandom_range(0, 3) == 0, 1'(($urandom))};
            1: return {2'b00, s, 2'b10, 1'($urandom)};
            2: return {6'b100010, 2'($urandom)};
            3: return {7'b1100011, 1'($urandom)};
            4: return {6'b101000, 2'($urandom)};
            5: return {6'b100000, 2'($urandom)};
            6: return {4'h7, 4'($urandom)};
            7: return {6'b111000, 2'($urandom)};
            8: return {4'hB, 4'($urandom)};
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_instr();
        logic [7:0] b;
        send(pick_opcode(), $urandom_range(0, 19) == 0);
        while (sb.busy()) begin
            b = ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom);
            send(b, $urandom_range(0, 19) == 0);
        end
    endtask

    logic [8:0] directed [] = '{
        9'h004, 9'h0FF, 9'h005, 9'h034, 9'h012, 9'h02D, 9'h000, 9'h080, 9'h03C, 9'h07F,
        9'h00C, 9'h000, 9'h0C0, 9'h03B, 9'h0FF, 9'h003, 9'h046, 9'h000,
        9'h08B, 9'h006, 9'h034, 9'h012, 9'h089, 9'h087, 9'h000, 9'h000,
        9'h08A, 9'h046, 9'h080, 9'h028, 9'h094, 9'h0FF, 9'h07F,
        9'h0C6, 9'h006, 9'h011, 9'h022, 9'h033,
        9'h0C7, 9'h084, 9'h034, 9'h012, 9'h078, 9'h056,
        9'h0A0, 9'h034, 9'h012, 9'h0A3, 9'h0FF, 9'h0FF,
        9'h080, 9'h0C8, 9'h083, 9'h0F9, 9'h080, 9'h081, 9'h0C2, 9'h034, 9'h012,
        9'h080, 9'h046, 9'h000, 9'h0FF,
        9'h0E0, 9'h0FE, 9'h0E3, 9'h000, 9'h070, 9'h080, 9'h07F, 9'h07F,
        9'h0B0, 9'h0FF, 9'h0BF, 9'h034, 9'h012, 9'h0F4, 9'h0FF,
        9'h005, 9'h134, 9'h18B, 9'h08B, 9'h086, 9'h112, 9'h08B, 9'h146,
        9'h080, 9'h0C0, 9'h1FF, 9'h170, 9'h0C7, 9'h006, 9'h134
    };

    initial begin
        sb = new();
        quiet = 1'b0;
        hold_req = 1'b0;
        cycles = 0;
        n_bytes = 0;
        in_ch.valid = 1'b0;
        in_ch.code_byte = 8'd0;
        in_ch.stream_end = 1'b0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i]) send(directed[i][7:0], directed[i][8]);
        hold_req = 1'b1;
        while (n_bytes < 2000) begin
            if (n_bytes > 1700) quiet = 1'b1;
            random_instr();
        end
        in_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Sent %0d code bytes; checked %0d records, %0d of them error records.",
                 n_bytes, sb.records_seen, sb.error_records);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("x86_16bit_instruction_decoder_tb: PASS");
        end else begin
            $display("x86_16bit_instruction_decoder_tb: FAIL");
        end
        $finish;
    end

endmodule
